@@ design/cfir_pkg.sv @@
// Package for the complex FIR channel filter: sample, tap and word types,
// widths, register count and reset constants. No dependencies.
package cfir_pkg;

    localparam int SAMPLE_W      = 16;                // Q1.15 part width
    localparam int FRAC_W        = 15;                // fraction bits of Q1.15
    localparam int TAP_COUNT     = 8;                 // tap registers
    localparam int HIST_DEPTH    = TAP_COUNT - 1;     // previous samples kept
    localparam int TAP_IDX_W     = $clog2(TAP_COUNT);
    localparam int CFG_IDX_W     = 4;                 // register index on the port
    localparam int CFG_DATA_W    = 2 * SAMPLE_W;
    localparam int PROD_W        = 2 * SAMPLE_W;      // exact Q2.30 product
    localparam int NTAPS_DEFAULT = TAP_COUNT;

    // Newest-sample tap resets to about 1.0 + 0j
    localparam logic [CFG_DATA_W-1:0] TAP_LAST_RESET = 32'h7FFF_0000;

    // Complex Q1.15 value, real part in the upper half
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } cplx_t;

    // Input word
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
        logic                       start_block;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_re;
        logic signed [SAMPLE_W-1:0] out_im;
        logic                       clipped;
    } out_word_t;

endpackage

@@ design/cfir_round_sat.sv @@
// Round-half-up of a full-precision sum of Q2.30 products to Q1.15 with saturation.
// Depends on cfir_pkg.
module cfir_round_sat #(
    parameter int ACC_W = 36
) (
    input  logic signed [ACC_W-1:0]              acc,
    output logic signed [cfir_pkg::SAMPLE_W-1:0] q,
    output logic                                 clip
);
    import cfir_pkg::*;

    localparam logic signed [ACC_W:0] HALF_LSB = (ACC_W+1)'(1) <<< (FRAC_W - 1);
    localparam logic signed [ACC_W:0] Q_MAX =
        {{(ACC_W+1-SAMPLE_W){1'b0}}, 1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [ACC_W:0] Q_MIN =
        {{(ACC_W+1-SAMPLE_W){1'b1}}, 1'b1, {(SAMPLE_W-1){1'b0}}};

    logic signed [ACC_W:0] biased;
    logic signed [ACC_W:0] scaled;

    // add half an output LSB one bit wider, then floor by shifting
    always_comb begin
        biased = $signed({acc[ACC_W-1], acc}) + HALF_LSB;
        scaled = biased >>> FRAC_W;
        priority if (scaled > Q_MAX) begin
            q    = Q_MAX[SAMPLE_W-1:0];
            clip = 1'b1;
        end else if (scaled < Q_MIN) begin
            q    = Q_MIN[SAMPLE_W-1:0];
            clip = 1'b1;
        end else begin
            q    = scaled[SAMPLE_W-1:0];
            clip = 1'b0;
        end
    end

endmodule

@@ design/complex_fir_channel_filter.sv @@
// Top level of the complex FIR channel filter: tap registers, sample history
// and a five-stage multiply/add pipeline. Depends on cfir_pkg, cfir_round_sat.
//
// Usage:
//   s_valid/s_ready/s_data move one complex Q1.15 input word; start_block in
//   the word clears the sample history before that sample enters the window.
//   m_valid/m_ready/m_data move one result word per input word, in order:
//   the sum over the newest NTAPS samples of tap times sample, rounded half
//   up to Q1.15 and saturated, with clipped set if either part saturated.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write tap register cfg_index
//   (tap_7 weights the newest sample); cfg_ready is always high and indexes
//   above the last tap are ignored. Write taps only while no word is in flight.
// Timing:
//   A result shows on m_valid once its input word has passed the window,
//   product, lane sum, accumulate and round/saturate registers.
//   One word per clock is taken and delivered as long as m_ready stays high.
//   A stalled receiver holds the result register; upstream stages keep
//   filling their bubbles, and s_ready drops only when all five are full.
// Reset:
//   aresetn clears the history, the pipeline valids and the taps; tap_7
//   comes back as 0x7FFF0000 (pass-through).
module complex_fir_channel_filter #(
    parameter int NTAPS = cfir_pkg::NTAPS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input words
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  cfir_pkg::in_word_t                   s_data,
    // result words
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output cfir_pkg::out_word_t                  m_data,
    // tap register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cfir_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cfir_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import cfir_pkg::*;

    localparam int FIRST_TAP = TAP_COUNT - NTAPS;
    localparam int LANE_W    = PROD_W + 1;
    localparam int ACC_W     = LANE_W + ((NTAPS > 1) ? $clog2(NTAPS) : 0);
    localparam int STAGES    = 5;
    localparam int S_WIN     = 0;
    localparam int S_PROD    = 1;
    localparam int S_LANE    = 2;
    localparam int S_ACC     = 3;
    localparam int S_OUT     = 4;

    // ---------------- state ----------------
    cplx_t                     tap_reg  [TAP_COUNT];
    cplx_t                     hist_reg [HIST_DEPTH];
    logic [STAGES-1:0]         valid_reg;
    logic [STAGES-1:0]         adv;

    cplx_t                     win_reg  [NTAPS];
    cplx_t                     win_next [NTAPS];
    logic signed [PROD_W-1:0]  rr_reg   [NTAPS];
    logic signed [PROD_W-1:0]  ii_reg   [NTAPS];
    logic signed [PROD_W-1:0]  ri_reg   [NTAPS];
    logic signed [PROD_W-1:0]  ir_reg   [NTAPS];
    logic signed [LANE_W-1:0]  lre_reg  [NTAPS];
    logic signed [LANE_W-1:0]  lim_reg  [NTAPS];
    logic signed [ACC_W-1:0]   acc_re_reg, acc_im_reg;
    logic signed [ACC_W-1:0]   acc_re_next, acc_im_next;
    out_word_t                 out_reg;

    cplx_t                     cur;
    logic                      s_fire;
    logic signed [SAMPLE_W-1:0] q_re, q_im;
    logic                      clip_re, clip_im;

    // ---------------- handshakes ----------------
    // a stage loads when it is empty or the next one moves
    always_comb begin
        adv[S_OUT] = !valid_reg[S_OUT] || m_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_ready   = adv[S_WIN];
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = valid_reg[S_OUT];
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[S_WIN]) begin
                valid_reg[S_WIN] <= s_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ---------------- tap registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < TAP_COUNT - 1; t++) begin
                tap_reg[t] <= '0;
            end
            tap_reg[TAP_COUNT-1] <= cplx_t'(TAP_LAST_RESET);
        end else if (cfg_valid && cfg_ready &&
                     (cfg_index < CFG_IDX_W'(TAP_COUNT))) begin
            tap_reg[cfg_index[TAP_IDX_W-1:0]] <= cplx_t'(cfg_data);
        end
    end

    // ---------------- history and sample window ----------------
    assign cur.re = s_data.sample_re;
    assign cur.im = s_data.sample_im;

    // lane j pairs with tap FIRST_TAP+j; the last lane holds the new sample
    always_comb begin
        for (int j = 0; j < NTAPS; j++) begin
            if (j == NTAPS - 1) begin
                win_next[j] = cur;
            end else if (s_data.start_block) begin
                win_next[j] = '0;
            end else begin
                win_next[j] = hist_reg[NTAPS-2-j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int h = 0; h < HIST_DEPTH; h++) begin
                hist_reg[h] <= '0;
            end
        end else if (s_fire) begin
            hist_reg[0] <= cur;
            for (int h = 1; h < HIST_DEPTH; h++) begin
                hist_reg[h] <= s_data.start_block ? '0 : hist_reg[h-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[S_WIN]) begin
            win_reg <= win_next;
        end
    end

    // ---------------- products ----------------
    always_ff @(posedge aclk) begin
        if (adv[S_PROD]) begin
            for (int j = 0; j < NTAPS; j++) begin
                rr_reg[j] <= tap_reg[FIRST_TAP+j].re * win_reg[j].re;
                ii_reg[j] <= tap_reg[FIRST_TAP+j].im * win_reg[j].im;
                ri_reg[j] <= tap_reg[FIRST_TAP+j].re * win_reg[j].im;
                ir_reg[j] <= tap_reg[FIRST_TAP+j].im * win_reg[j].re;
            end
        end
    end

    // ---------------- per-lane complex combine ----------------
    always_ff @(posedge aclk) begin
        if (adv[S_LANE]) begin
            for (int j = 0; j < NTAPS; j++) begin
                lre_reg[j] <= LANE_W'(rr_reg[j]) - LANE_W'(ii_reg[j]);
                lim_reg[j] <= LANE_W'(ri_reg[j]) + LANE_W'(ir_reg[j]);
            end
        end
    end

    // ---------------- sum across lanes ----------------
    always_comb begin
        acc_re_next = '0;
        acc_im_next = '0;
        for (int j = 0; j < NTAPS; j++) begin
            acc_re_next = acc_re_next + ACC_W'(lre_reg[j]);
            acc_im_next = acc_im_next + ACC_W'(lim_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[S_ACC]) begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    // ---------------- round, saturate, result register ----------------
    cfir_round_sat #(.ACC_W(ACC_W)) u_round_re (
        .acc  (acc_re_reg),
        .q    (q_re),
        .clip (clip_re)
    );

    cfir_round_sat #(.ACC_W(ACC_W)) u_round_im (
        .acc  (acc_im_reg),
        .q    (q_im),
        .clip (clip_im)
    );

    always_ff @(posedge aclk) begin
        if (adv[S_OUT]) begin
            out_reg.out_re  <= q_re;
            out_reg.out_im  <= q_im;
            out_reg.clipped <= clip_re || clip_im;
        end
    end

    // ---------------- assertions ----------------
    // input stalls only with every stage full and the receiver stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> ((&valid_reg) && !m_ready))
        else $error("s_ready low with room in the pipeline");

    // no result word right after reset
    assert property (@(posedge aclk) $past(!aresetn) |-> !m_valid)
        else $error("m_valid high right after reset");

    // a clipped word carries a saturated part
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.clipped) |->
            (m_data.out_re == {1'b0, {(SAMPLE_W-1){1'b1}}} ||
             m_data.out_re == {1'b1, {(SAMPLE_W-1){1'b0}}} ||
             m_data.out_im == {1'b0, {(SAMPLE_W-1){1'b1}}} ||
             m_data.out_im == {1'b1, {(SAMPLE_W-1){1'b0}}}))
        else $error("clipped set without a saturated part");

    // block start leaves only the new sample in the history
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.start_block) |=>
            (hist_reg[HIST_DEPTH-1] == '0 && hist_reg[0] == $past(cur)))
        else $error("history not cleared on block start");

endmodule

@@ bench/cfir_checker.sv @@
// Checker for the complex FIR channel filter: tracks tap writes and input
// words, predicts each result word and compares it with the DUT output.
// Depends on cfir_pkg.
module cfir_checker #(
    parameter int NTAPS = cfir_pkg::NTAPS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  cfir_pkg::in_word_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  cfir_pkg::out_word_t             m_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [cfir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfir_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              outstanding
);
    import cfir_pkg::*;

    // Leading taps drop out when the filter is built shorter
    localparam int FIRST_TAP = (NTAPS >= TAP_COUNT) ? 0 :
                               ((NTAPS <= 1) ? TAP_COUNT - 1 : TAP_COUNT - NTAPS);
    localparam longint PART_MAX     = 2 ** (SAMPLE_W - 1) - 1;
    localparam longint PART_MIN     = -(2 ** (SAMPLE_W - 1));
    localparam int     REPORT_LIMIT = 10;

    cplx_t     taps [TAP_COUNT];
    cplx_t     window [HIST_DEPTH];   // 0 = previous sample, last = oldest
    out_word_t pending_outputs [$];

    // Round half up from a sum of Q2.30 products to Q1.15, then clamp to 16 bits
    function automatic logic signed [SAMPLE_W-1:0] round_saturate(input longint acc,
                                                                  inout logic clip);
        longint r;
        r = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        if (r > PART_MAX) begin
            r = PART_MAX;
            clip = 1'b1;
        end else if (r < PART_MIN) begin
            r = PART_MIN;
            clip = 1'b1;
        end
        return r[SAMPLE_W-1:0];
    endfunction

    // Complex dot product of taps and the sample window; clears the window on a block start and shifts it
    function automatic out_word_t filter_step(input in_word_t w);
        cplx_t     cur;
        cplx_t     s;
        longint    acc_re;
        longint    acc_im;
        longint    sr;
        longint    si;
        longint    tr;
        longint    ti;
        logic      clip;
        int        k;
        int        age;
        out_word_t res;

        cur.re = w.sample_re;
        cur.im = w.sample_im;
        if (w.start_block) begin
            for (k = 0; k < HIST_DEPTH; k++) window[k] = '0;
        end
        acc_re = 0;
        acc_im = 0;
        clip   = 1'b0;
        for (k = FIRST_TAP; k < TAP_COUNT; k++) begin
            age = TAP_COUNT - 1 - k;
            if (age == 0) begin
                s = cur;
            end else begin
                s = window[age-1];
            end
            sr = s.re;
            si = s.im;
            tr = taps[k].re;
            ti = taps[k].im;
            acc_re += tr * sr - ti * si;
            acc_im += tr * si + ti * sr;
        end
        for (k = HIST_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = cur;

        res.out_re  = round_saturate(acc_re, clip);
        res.out_im  = round_saturate(acc_im, clip);
        res.clipped = clip;
        return res;
    endfunction

    // Sample all three channels at the clock edge
    always @(posedge aclk) begin : monitor
        out_word_t want;
        if (!aresetn) begin
            foreach (taps[k]) taps[k] = '0;
            taps[TAP_COUNT-1] = TAP_LAST_RESET;
            foreach (window[k]) window[k] = '0;
            pending_outputs.delete();
            fail_count  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_outputs.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result word re=%0d im=%0d clipped=%0b",
                                 $time, m_data.out_re, m_data.out_im, m_data.clipped);
                    end
                end else begin
                    want = pending_outputs.pop_front();
                    if (m_data.out_re !== want.out_re || m_data.out_im !== want.out_im ||
                        m_data.clipped !== want.clipped) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("%0t: result mismatch: expected re=%0d im=%0d clipped=%0b, got re=%0d im=%0d clipped=%0b",
                                     $time, want.out_re, want.out_im, want.clipped,
                                     m_data.out_re, m_data.out_im, m_data.clipped);
                        end
                    end
                end
            end
            // indexes past the last tap are dropped
            if (cfg_valid && cfg_ready && cfg_index < TAP_COUNT) begin
                taps[cfg_index[TAP_IDX_W-1:0]] = cfg_data;
            end
            if (s_valid && s_ready) begin
                pending_outputs.push_back(filter_step(s_data));
            end
        end
        outstanding = pending_outputs.size();
    end

endmodule

@@ bench/complex_fir_channel_filter_test.sv @@
// Testbench top for the complex FIR channel filter: clock, reset, tap
// programming and random input/result traffic. Depends on cfir_pkg,
// cfir_checker and the complex_fir_channel_filter RTL.
module complex_fir_channel_filter_test;
    import cfir_pkg::*;

    localparam int FILTER_TAPS    = NTAPS_DEFAULT;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_WORDS    = 145;
    localparam int MAX_IDLE       = 16;
    localparam int SETTLE_CYCLES  = 8;       // pipeline is five deep
    localparam int LIMIT_CYCLES   = 400000;
    localparam int REG_INDEX_MAX  = 2 ** CFG_IDX_W - 1;

    localparam logic [SAMPLE_W-1:0] Q_MAX  = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] Q_MIN  = 16'h8000;
    localparam logic [SAMPLE_W-1:0] Q_ZERO = 16'h0000;
    localparam logic [SAMPLE_W-1:0] Q_NEG1 = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] Q_POS1 = 16'h0001;

    typedef enum int {
        TAPS_KEEP, TAPS_PASS, TAPS_ZERO, TAPS_MAX, TAPS_MIN,
        TAPS_RANDOM, TAPS_SMALL, TAPS_SPARSE, TAPS_EXTREMES
    } tap_mode_e;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    always #5 aclk = ~aclk;

    complex_fir_channel_filter #(.NTAPS(FILTER_TAPS)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cfir_checker #(.NTAPS(FILTER_TAPS)) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic int draw_idle(input bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic in_word_t word_of(input logic [SAMPLE_W-1:0] re,
                                         input logic [SAMPLE_W-1:0] im,
                                         input logic start);
        in_word_t w;
        w.sample_re   = re;
        w.sample_im   = im;
        w.start_block = start;
        return w;
    endfunction

    // Full-scale, zero and -1 values show up often, the rest is uniform
    function automatic logic [SAMPLE_W-1:0] random_part();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = Q_MAX;
            1:       v = Q_MIN;
            2:       v = Q_ZERO;
            3:       v = Q_NEG1;
            default: v = SAMPLE_W'($urandom());
        endcase
        return v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] extreme_part();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = Q_MAX;
            1:       v = Q_MIN;
            2:       v = Q_ZERO;
            default: v = Q_NEG1;
        endcase
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] tap_value(input tap_mode_e mode,
                                                        input bit hot);
        logic [SAMPLE_W-1:0] re;
        logic [SAMPLE_W-1:0] im;
        case (mode)
            TAPS_PASS: begin
                re = hot ? Q_MAX : Q_ZERO;
                im = Q_ZERO;
            end
            TAPS_MAX: begin
                re = Q_MAX;
                im = Q_MAX;
            end
            TAPS_MIN: begin
                re = Q_MIN;
                im = Q_MIN;
            end
            TAPS_RANDOM: begin
                re = SAMPLE_W'($urandom());
                im = SAMPLE_W'($urandom());
            end
            // eighth-scale taps keep most sums inside full scale
            TAPS_SMALL: begin
                re = SAMPLE_W'($urandom_range(0, 8191) - 4096);
                im = SAMPLE_W'($urandom_range(0, 8191) - 4096);
            end
            TAPS_SPARSE: begin
                re = hot ? random_part() : Q_ZERO;
                im = hot ? random_part() : Q_ZERO;
            end
            TAPS_EXTREMES: begin
                re = extreme_part();
                im = extreme_part();
            end
            default: begin
                re = Q_ZERO;
                im = Q_ZERO;
            end
        endcase
        return {re, im};
    endfunction

    // Input word; valid stays up across back-to-back words
    task automatic send_word(input in_word_t w);
        int idle;
        idle = draw_idle(tx_quiet);
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Every tap per mode (none for TAPS_KEEP), then one write to an index past the last tap
    task automatic program_taps(input tap_mode_e mode);
        int k;
        int hot;
        hot = (mode == TAPS_PASS) ? TAP_COUNT - 1 : $urandom_range(0, TAP_COUNT - 1);
        if (mode != TAPS_KEEP) begin
            for (k = 0; k < TAP_COUNT; k++) begin
                write_reg(CFG_IDX_W'(k), tap_value(mode, k == hot));
            end
        end
        write_reg(CFG_IDX_W'($urandom_range(TAP_COUNT, REG_INDEX_MAX)), $urandom());
        cfg_valid <= 1'b0;
    endtask

    // Hold off input until every result word is back and the pipe is empty
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Result side: random stall before each word, ready held otherwise
    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_idle(rx_quiet);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** complex_fir_channel_filter: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        tap_mode_e schedule [PHASE_COUNT];
        int p;
        int i;

        schedule = '{TAPS_RANDOM, TAPS_MAX, TAPS_SMALL, TAPS_MIN, TAPS_SPARSE,
                     TAPS_EXTREMES, TAPS_ZERO, TAPS_PASS, TAPS_RANDOM, TAPS_SMALL};
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset taps pass the newest sample through
        send_word(word_of(Q_MAX, Q_MIN, 1'b1));
        send_word(word_of(Q_MIN, Q_MAX, 1'b0));
        send_word(word_of(Q_ZERO, Q_ZERO, 1'b0));
        send_word(word_of(Q_NEG1, Q_POS1, 1'b0));
        send_word(word_of(Q_MAX, Q_MAX, 1'b0));
        wait_idle();

        // Most negative taps: -1 * -1 products pile up past full scale
        program_taps(TAPS_MIN);
        send_word(word_of(Q_MIN, Q_MIN, 1'b1));
        send_word(word_of(Q_MIN, Q_MIN, 1'b0));
        send_word(word_of(Q_MIN, Q_MAX, 1'b0));
        send_word(word_of(Q_MAX, Q_MIN, 1'b0));
        send_word(word_of(Q_MAX, Q_MAX, 1'b1));
        send_word(word_of(Q_MAX, Q_MAX, 1'b0));
        wait_idle();

        // Largest taps, block starts mid-stream
        program_taps(TAPS_MAX);
        send_word(word_of(Q_MAX, Q_MAX, 1'b1));
        send_word(word_of(Q_MAX, Q_MIN, 1'b0));
        send_word(word_of(Q_MIN, Q_MIN, 1'b0));
        send_word(word_of(Q_MIN, Q_MAX, 1'b1));
        send_word(word_of(Q_POS1, Q_NEG1, 1'b0));
        wait_idle();

        // An out-of-range index alone must not disturb the taps
        program_taps(TAPS_KEEP);
        send_word(word_of(Q_NEG1, Q_NEG1, 1'b1));
        send_word(word_of(Q_MAX, Q_ZERO, 1'b0));
        send_word(word_of(Q_ZERO, Q_MIN, 1'b0));

        // Random blocks of samples under each tap setting
        for (p = 0; p < PHASE_COUNT; p++) begin
            wait_idle();
            program_taps(schedule[p]);
            tx_quiet = (p % 3 == 0) || ($urandom_range(0, 3) == 0);
            rx_quiet = (p % 3 == 0) || ($urandom_range(0, 3) == 0);
            for (i = 0; i < PHASE_WORDS; i++) begin
                send_word(word_of(random_part(), random_part(),
                                  (i == 0) || ($urandom_range(0, 15) == 0)));
            end
        end

        wait_idle();
        if (fail_count == 0 && outstanding == 0) begin
            $display("** complex_fir_channel_filter: PASSED **");
        end else begin
            $display("** complex_fir_channel_filter: FAILED **");
        end
        $finish;
    end

endmodule
